// File: hdl/ulaw_playback_stretch_mixer_macros.svh
// Assertion macros for the mu-law playback stretch mixer.
// Used by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef ULAW_PLAYBACK_STRETCH_MIXER_MACROS_SVH
`define ULAW_PLAYBACK_STRETCH_MIXER_MACROS_SVH

`define ULPSM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ulpsm assertion failed");

`define ULPSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ulpsm assertion failed");

`endif

// File: hdl/ulpsm_pkg.sv
// Package for the mu-law playback stretch mixer.
// Holds the item structs, the register set type and the register indexes.
package ulpsm_pkg;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam logic [14:0] MuBias = 15'd132;
  localparam logic signed [16:0] PcmMax = 17'sd32767;
  localparam logic signed [16:0] PcmMin = -17'sd32768;

  typedef enum logic {
    REG_RATE_MODE  = 1'b0,
    REG_WIDTH_MODE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]         ulaw_code;
    logic               packet_start;
    logic               mix_enable;
    logic signed [15:0] existing_first;
    logic signed [15:0] existing_second;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               last_of_item;
  } out_item_t;

  typedef struct packed {
    logic rate_mode;
    logic width_mode;
  } cfg_t;

endpackage

// File: hdl/ulpsm_regs.sv
// APB configuration registers for the mu-law playback stretch mixer.
// Depends on ulpsm_pkg.
module ulpsm_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ulpsm_pkg::AddrW-1:0] paddr,
  input  logic [ulpsm_pkg::DataW-1:0] pwdata,
  output logic [ulpsm_pkg::DataW-1:0] prdata,
  output logic                        pready,
  output ulpsm_pkg::cfg_t             cfg_o
);
  import ulpsm_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_RATE_MODE:  cfg_d.rate_mode  = pwdata[0];
        REG_WIDTH_MODE: cfg_d.width_mode = pwdata[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RATE_MODE:  prdata = {{(DataW-1){1'b0}}, cfg_q.rate_mode};
      REG_WIDTH_MODE: prdata = {{(DataW-1){1'b0}}, cfg_q.width_mode};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/ulpsm_expand.sv
// Mu-law to 16-bit linear PCM expander, purely combinational.
// Depends on ulpsm_pkg.
module ulpsm_expand (
  input  logic [7:0]         code_i,
  output logic signed [15:0] lin_o
);
  import ulpsm_pkg::*;

  logic [7:0]  u;
  logic [2:0]  ex;
  logic [14:0] base;
  logic [14:0] mag;

  assign u    = ~code_i;
  assign ex   = u[6:4];
  assign base = {8'd0, u[3:0], 3'd0} + MuBias;
  assign mag  = (base << ex) - MuBias;
  assign lin_o = u[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// File: hdl/ulpsm_mix.sv
// Output sample former: width conversion and optional mix with a buffer sample.
// Depends on ulpsm_pkg.
module ulpsm_mix (
  input  logic signed [15:0] lin_i,
  input  logic               mix_i,
  input  logic               width8_i,
  input  logic signed [15:0] existing_i,
  output logic signed [15:0] sample_o
);
  import ulpsm_pkg::*;

  logic [7:0]         b;
  logic [7:0]         b_mix;
  logic signed [16:0] sum;
  logic signed [15:0] sat;

  assign b     = lin_i[15:8] ^ 8'h80;
  assign b_mix = mix_i ? (b + existing_i[7:0]) : b;
  assign sum   = 17'(lin_i) + 17'(existing_i);

  always_comb begin
    if (!mix_i) begin
      sat = lin_i;
    end else if (sum > PcmMax) begin
      sat = PcmMax[15:0];
    end else if (sum < PcmMin) begin
      sat = PcmMin[15:0];
    end else begin
      sat = sum[15:0];
    end
  end

  assign sample_o = width8_i ? $signed({8'd0, b_mix}) : sat;

endmodule

// File: hdl/ulaw_playback_stretch_mixer.sv
// Top level of the mu-law playback stretch mixer.
// Depends on ulpsm_pkg, ulpsm_regs, ulpsm_expand, ulpsm_mix and the macro header.
//
//   Channel   Handshake              Payload
//   in        in_valid_i/in_stall_o  in_i   (ulpsm_pkg::in_item_t)
//   out       out_valid_o/out_stall_i out_o (ulpsm_pkg::out_item_t)
//   config    APB psel/penable       paddr, pwdata, prdata
//
// An item is expanded and mixed combinationally into the result register.
// Each item gives one result, or two on a stretch duplicate, one per cycle while out_stall_i is low.
// A new item is taken in the cycle its predecessor's last result leaves.
// Reset clears the config registers, the stretch phase, the output select and the result valid flag.
`include "ulaw_playback_stretch_mixer_macros.svh"
module ulaw_playback_stretch_mixer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ulpsm_pkg::in_item_t         in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ulpsm_pkg::out_item_t        out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ulpsm_pkg::AddrW-1:0] paddr,
  input  logic [ulpsm_pkg::DataW-1:0] pwdata,
  output logic [ulpsm_pkg::DataW-1:0] prdata,
  output logic                        pready
);
  import ulpsm_pkg::*;

  cfg_t               cfg;
  logic signed [15:0] lin;
  logic signed [15:0] s0, s1;
  logic [2:0]         ph;
  logic [2:0]         phase_q, phase_d;
  logic               dup;
  logic               in_acc, out_acc, out_last;
  logic               valid_q, valid_d;
  logic               sel_q, sel_d;
  logic               dup_q;
  logic signed [15:0] s0_q, s1_q;

  ulpsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ulpsm_expand u_expand (
    .code_i (in_i.ulaw_code),
    .lin_o  (lin)
  );

  ulpsm_mix u_mix_first (
    .lin_i      (lin),
    .mix_i      (in_i.mix_enable),
    .width8_i   (cfg.width_mode),
    .existing_i (in_i.existing_first),
    .sample_o   (s0)
  );

  ulpsm_mix u_mix_second (
    .lin_i      (lin),
    .mix_i      (in_i.mix_enable),
    .width8_i   (cfg.width_mode),
    .existing_i (in_i.existing_second),
    .sample_o   (s1)
  );

  assign ph  = in_i.packet_start ? 3'd0 : phase_q;
  assign dup = cfg.rate_mode & (ph != 3'd0) & ~ph[0];

  assign out_last    = sel_q | ~dup_q;
  assign out_valid_o = valid_q;
  assign out_acc     = valid_q & ~out_stall_i;
  assign in_stall_o  = valid_q & ~(out_acc & out_last);
  assign in_acc      = in_valid_i & ~in_stall_o;

  assign out_o.pcm_sample   = sel_q ? s1_q : s0_q;
  assign out_o.last_of_item = out_last;

  always_comb begin
    phase_d = phase_q;
    valid_d = valid_q;
    sel_d   = sel_q;
    if (in_acc) begin
      phase_d = ph + 3'd1;
      valid_d = 1'b1;
      sel_d   = 1'b0;
    end else if (out_acc) begin
      if (out_last) begin
        valid_d = 1'b0;
      end else begin
        sel_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_q  <= s0;
      s1_q  <= s1;
      dup_q <= dup;
    end
  end

  `ULPSM_ASSERT_NEXT(a_dup_second_follows, out_acc && !out_last, out_valid_o && out_last)
  `ULPSM_ASSERT_NEXT(a_start_sets_phase, in_acc && in_i.packet_start, phase_q == 3'd1)
  `ULPSM_ASSERT_SAME(a_no_take_over_pending, in_acc && valid_q, out_acc && out_last)

endmodule

// File: tb/tb.sv
// Self-checking testbench for the mu-law playback stretch mixer.
// Predicts the expanded, stretched and mixed samples for each item and checks the
// result channel in order; depends on ulpsm_pkg and the ulaw_playback_stretch_mixer RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ulpsm_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemsPerSetting = 376;
  localparam logic [4:0] RateSeq = 5'b10011;
  localparam logic [4:0] WidthSeq = 5'b00110;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t dut_out;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  out_item_t pending_samples[$];
  cfg_t shadow_cfg;
  logic [2:0] shadow_phase;
  int unsigned errors;
  int unsigned cycles;
  logic quiet;
  logic calm_in;
  logic calm_out;

  ulaw_playback_stretch_mixer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (dut_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [15:0] expand_ulaw(input logic [7:0] code);
    logic [7:0] u;
    int mag;
    u = ~code;
    mag = ((int'(u[3:0]) << 3) + int'(MuBias)) << u[6:4];
    mag = mag - int'(MuBias);
    return u[7] ? 16'(-mag) : 16'(mag);
  endfunction

  function automatic logic [15:0] mix_sample(input logic signed [15:0] lin, input logic mix,
                                             input logic signed [15:0] existing);
    logic [7:0] b;
    int r;
    if (shadow_cfg.width_mode) begin
      b = lin[15:8] ^ 8'h80;
      if (mix) b = b + existing[7:0];
      return {8'h00, b};
    end
    r = int'(lin);
    if (mix) begin
      r = r + int'(existing);
      if (r > int'(PcmMax)) r = int'(PcmMax);
      if (r < int'(PcmMin)) r = int'(PcmMin);
    end
    return r[15:0];
  endfunction

  task automatic predict_ulaw_item(input in_item_t it);
    logic [2:0] ph;
    logic dup;
    logic signed [15:0] lin;
    out_item_t res;
    ph = it.packet_start ? 3'd0 : shadow_phase;
    dup = shadow_cfg.rate_mode && ph != 3'd0 && !ph[0];
    shadow_phase = ph + 3'd1;
    lin = expand_ulaw(it.ulaw_code);
    res.pcm_sample = mix_sample(lin, it.mix_enable, it.existing_first);
    res.last_of_item = !dup;
    pending_samples.push_back(res);
    if (dup) begin
      res.pcm_sample = mix_sample(lin, it.mix_enable, it.existing_second);
      res.last_of_item = 1'b1;
      pending_samples.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    $display("mismatch on %s: got %h, expected %h, cycle %0d", what, got, want, cycles);
  endtask

  // Leaves valid high after acceptance so that a following item can go back to back.
  task automatic push_ulaw_item(input in_item_t it);
    int unsigned gap;
    gap = 0;
    if (!quiet && !calm_in && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_ulaw_item(it);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    wait (pending_samples.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== DataW'(value)) report_mismatch("register readback", prdata[15:0],
                                                  16'(value));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_RATE_MODE: shadow_cfg.rate_mode = value;
      REG_WIDTH_MODE: shadow_cfg.width_mode = value;
      default: ;
    endcase
  endtask

  function automatic in_item_t make_item(input logic [7:0] code, input logic start,
                                         input logic mix, input logic [15:0] first,
                                         input logic [15:0] second);
    in_item_t it;
    it.ulaw_code = code;
    it.packet_start = start;
    it.mix_enable = mix;
    it.existing_first = first;
    it.existing_second = second;
    return it;
  endfunction

  function automatic logic [15:0] pick_existing();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed_8k16();
    cfg_write(REG_RATE_MODE, 1'b0);
    cfg_write(REG_WIDTH_MODE, 1'b0);
    push_ulaw_item(make_item(8'hFF, 1'b1, 1'b0, 16'h1234, 16'h4321));
    push_ulaw_item(make_item(8'h7F, 1'b0, 1'b0, 16'h0000, 16'hFFFF));
    push_ulaw_item(make_item(8'h80, 1'b0, 1'b0, 16'h5555, 16'hAAAA));
    push_ulaw_item(make_item(8'h00, 1'b0, 1'b0, 16'hAAAA, 16'h5555));
    push_ulaw_item(make_item(8'h80, 1'b0, 1'b1, 16'h7FFF, 16'h0000));
    push_ulaw_item(make_item(8'h00, 1'b0, 1'b1, 16'h8000, 16'h0000));
    push_ulaw_item(make_item(8'h55, 1'b0, 1'b0, 16'hBEEF, 16'hCAFE));
    push_ulaw_item(make_item(8'h2A, 1'b0, 1'b1, 16'd1234, 16'hFFFF));
    drain_outputs();
  endtask

  task automatic test_directed_11k16();
    cfg_write(REG_RATE_MODE, 1'b1);
    push_ulaw_item(make_item(8'h80, 1'b1, 1'b1, 16'd1000, 16'd2000));
    push_ulaw_item(make_item(8'h00, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF));
    push_ulaw_item(make_item(8'h80, 1'b0, 1'b1, 16'h0000, 16'h7FFF));
    push_ulaw_item(make_item(8'h00, 1'b0, 1'b1, 16'h8000, 16'd5));
    push_ulaw_item(make_item(8'h3C, 1'b0, 1'b0, 16'd7, 16'd7));
    push_ulaw_item(make_item(8'hC3, 1'b0, 1'b1, -16'sd300, 16'd300));
    push_ulaw_item(make_item(8'h80, 1'b0, 1'b1, 16'h7FFF, 16'h8000));
    push_ulaw_item(make_item(8'h11, 1'b0, 1'b1, 16'h0000, 16'h0000));
    push_ulaw_item(make_item(8'h22, 1'b0, 1'b1, 16'd1, 16'd1));
    push_ulaw_item(make_item(8'h80, 1'b1, 1'b1, 16'h0100, 16'h0200));
    push_ulaw_item(make_item(8'h44, 1'b0, 1'b0, 16'h0300, 16'h0400));
    push_ulaw_item(make_item(8'h45, 1'b1, 1'b0, 16'h0500, 16'h0600));
    drain_outputs();
  endtask

  task automatic test_directed_8bit();
    cfg_write(REG_WIDTH_MODE, 1'b1);
    push_ulaw_item(make_item(8'h80, 1'b1, 1'b1, 16'h7F01, 16'h0000));
    push_ulaw_item(make_item(8'h00, 1'b0, 1'b1, 16'h00FF, 16'hFF00));
    push_ulaw_item(make_item(8'hFF, 1'b0, 1'b1, 16'h12FF, 16'hAB80));
    push_ulaw_item(make_item(8'h7F, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF));
    push_ulaw_item(make_item(8'h10, 1'b0, 1'b1, 16'h8080, 16'h7F7F));
    drain_outputs();
    cfg_write(REG_RATE_MODE, 1'b0);
    push_ulaw_item(make_item(8'h80, 1'b0, 1'b1, 16'h00FF, 16'h0001));
    drain_outputs();
  endtask

  task automatic test_random_packets();
    in_item_t it;
    int unsigned sent;
    int unsigned len;
    logic start_ok;
    for (int s = 0; s < 5; s++) begin
      drain_outputs();
      cfg_write(REG_RATE_MODE, RateSeq[s]);
      cfg_write(REG_WIDTH_MODE, WidthSeq[s]);
      if (s == 4) quiet = 1'b1;
      sent = 0;
      while (sent < ItemsPerSetting) begin
        len = $urandom_range(1, 24);
        start_ok = ($urandom_range(0, 7) != 0);
        for (int k = 0; k < len; k++) begin
          it.ulaw_code = 8'($urandom_range(0, 255));
          it.packet_start = (k == 0) ? start_ok : ($urandom_range(0, 31) == 0);
          it.mix_enable = ($urandom_range(0, 3) != 0);
          it.existing_first = pick_existing();
          it.existing_second = pick_existing();
          push_ulaw_item(it);
          sent++;
          if (s == 1 && sent == ItemsPerSetting / 2) drain_outputs();
        end
      end
    end
  endtask

  initial begin
    int unsigned burst;
    burst = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (burst == 0 && !quiet && !calm_out && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 6);
      end
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    calm_in = 1'b0;
    calm_out = 1'b0;
    forever begin
      repeat (128) @(negedge clk_i);
      calm_in = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected item", dut_out.pcm_sample, 16'h0000);
      end else begin
        want = pending_samples.pop_front();
        if (dut_out.pcm_sample !== want.pcm_sample) begin
          report_mismatch("pcm_sample", dut_out.pcm_sample, want.pcm_sample);
        end
        if (dut_out.last_of_item !== want.last_of_item) begin
          report_mismatch("last_of_item", 16'(dut_out.last_of_item), 16'(want.last_of_item));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    shadow_cfg = '0;
    shadow_phase = 3'd0;
    rst_ni = 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_8k16();
    test_directed_11k16();
    test_directed_8bit();
    test_random_packets();
    drain_outputs();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
